### sv/mtx4_pkg.sv
// Shared constants and control types for the 4x4 fixed-point matrix multiplier.
// No dependencies; imported by the lane, merge and top-level modules.
package mtx4_pkg;

	localparam int DIM       = 4;
	localparam int ROW_BITS  = 2;
	localparam int FRAC_BITS = 16;

	// Controller states
	localparam logic ST_LOAD = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	// Row tag that travels down the pipeline next to the data
	typedef struct packed {
		logic [ROW_BITS-1:0] row;
		logic                last;
	} row_ctl_t;

endpackage

### sv/mtx4_lane.sv
// One column lane: four signed products, registered, then their exact sum.
// Depends on mtx4_pkg.
module mtx4_lane import mtx4_pkg::*; #(
	parameter int WORD_BITS = 32
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [WORD_BITS-1:0]   a_row [DIM],
	input  logic signed [WORD_BITS-1:0]   b_col [DIM],
	output logic signed [2*WORD_BITS+1:0] sum_s2
);

	localparam int PW = 2 * WORD_BITS;
	localparam int SW = 2 * WORD_BITS + 2;

	logic signed [PW-1:0] prod_s1 [DIM];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < DIM; k++) begin
				prod_s1[k] <= a_row[k] * b_col[k];
			end
		end
	end

	// Exact sum, two guard bits so it never wraps
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2 <= SW'(prod_s1[0]) + SW'(prod_s1[1]) + SW'(prod_s1[2]) + SW'(prod_s1[3]);
		end
	end

endmodule

### sv/mtx4_merge.sv
// Merge stage: shifts and saturates the four lane sums into one output row register.
// Depends on mtx4_pkg.
module mtx4_merge import mtx4_pkg::*; #(
	parameter int WORD_BITS = 32
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [2*WORD_BITS+1:0] sum [DIM],
	input  row_ctl_t                      ctl,
	output logic signed [WORD_BITS-1:0]   c_q [DIM],
	output row_ctl_t                      ctl_q
);

	localparam int SW = 2 * WORD_BITS + 2;

	logic signed [SW-1:0]        shifted [DIM];
	logic signed [WORD_BITS-1:0] sat     [DIM];

	always_comb begin
		for (int c = 0; c < DIM; c++) begin
			shifted[c] = sum[c] >>> FRAC_BITS;
			// Fits when every bit above the word's sign bit matches it
			if (shifted[c][SW-1:WORD_BITS-1] == '0 || shifted[c][SW-1:WORD_BITS-1] == '1) begin
				sat[c] = shifted[c][WORD_BITS-1:0];
			end else if (shifted[c][SW-1]) begin
				sat[c] = {1'b1, {(WORD_BITS-1){1'b0}}};
			end else begin
				sat[c] = {1'b0, {(WORD_BITS-1){1'b1}}};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_q   <= sat;
			ctl_q <= ctl;
		end
	end

endmodule

### sv/matrix4x4_multiply.sv
// 4x4 signed fixed-point matrix multiply, C = A x B: four column lanes plus a merge stage.
// After row 3 of A and B is taken, rows 0..3 of C are issued to the lanes in order.
// One row of C per cycle unless out_ready stalls; four rows load, then four issue,
// since the single set of operand registers takes no new row while rows are issued.
// Reset (arst_n low, asynchronous) empties the pipeline and restarts loading at row 0.
// Depends on mtx4_pkg, mtx4_lane and mtx4_merge.
module matrix4x4_multiply import mtx4_pkg::*; #(
	parameter int WORD_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [WORD_BITS-1:0] a_e0,
	input  logic signed [WORD_BITS-1:0] a_e1,
	input  logic signed [WORD_BITS-1:0] a_e2,
	input  logic signed [WORD_BITS-1:0] a_e3,
	input  logic signed [WORD_BITS-1:0] b_e0,
	input  logic signed [WORD_BITS-1:0] b_e1,
	input  logic signed [WORD_BITS-1:0] b_e2,
	input  logic signed [WORD_BITS-1:0] b_e3,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [WORD_BITS-1:0] c_e0,
	output logic signed [WORD_BITS-1:0] c_e1,
	output logic signed [WORD_BITS-1:0] c_e2,
	output logic signed [WORD_BITS-1:0] c_e3,
	output logic [ROW_BITS-1:0]         out_row,
	output logic                        last_row
);

	localparam int SW = 2 * WORD_BITS + 2;

	// Operand registers: rows of A and B, written one row per input transaction
	logic signed [WORD_BITS-1:0] a_rows_q [DIM][DIM];
	logic signed [WORD_BITS-1:0] b_rows_q [DIM][DIM];

	logic                state_q;
	logic [ROW_BITS-1:0] load_row_q;
	logic [ROW_BITS-1:0] issue_row_q;

	logic     v_s1, v_s2, out_valid_q;
	row_ctl_t ctl_s1, ctl_s2, ctl_out;

	logic in_fire;
	logic issue;
	logic adv;

	logic signed [WORD_BITS-1:0] a_sel [DIM];
	logic signed [WORD_BITS-1:0] b_col [DIM][DIM];
	logic signed [SW-1:0]        lane_sum [DIM];
	logic signed [WORD_BITS-1:0] c_q [DIM];

	assign in_ready = (state_q == ST_LOAD);
	assign in_fire  = in_valid && in_ready;
	assign issue    = (state_q == ST_RUN);
	// Whole pipeline moves together; stall everything while the output row waits
	assign adv      = !out_valid_q || out_ready;

	// Store the incoming row pair at the current load slot
	always_ff @(posedge clk) begin
		if (in_fire) begin
			a_rows_q[load_row_q][0] <= a_e0;
			a_rows_q[load_row_q][1] <= a_e1;
			a_rows_q[load_row_q][2] <= a_e2;
			a_rows_q[load_row_q][3] <= a_e3;
			b_rows_q[load_row_q][0] <= b_e0;
			b_rows_q[load_row_q][1] <= b_e1;
			b_rows_q[load_row_q][2] <= b_e2;
			b_rows_q[load_row_q][3] <= b_e3;
		end
	end

	// Load rows 0..3, then issue rows 0..3 of C to the lanes and go back to loading.
	// The operands are consumed at issue, so loading of the next matrix may overlap the drain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			load_row_q  <= '0;
			issue_row_q <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_fire) begin
						load_row_q <= load_row_q + 1'b1;
						if (load_row_q == ROW_BITS'(DIM - 1)) begin
							state_q     <= ST_RUN;
							issue_row_q <= '0;
						end
					end
				end
				ST_RUN: begin
					if (adv) begin
						issue_row_q <= issue_row_q + 1'b1;
						if (issue_row_q == ROW_BITS'(DIM - 1)) begin
							state_q <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// Valid bits of the lane stages and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= issue;
			v_s2        <= v_s1;
			out_valid_q <= v_s2;
		end
	end

	// Row tag follows the data through the lane stages
	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1.row  <= issue_row_q;
			ctl_s1.last <= (issue_row_q == ROW_BITS'(DIM - 1));
			ctl_s2      <= ctl_s1;
		end
	end

	// Pick row r of A for every lane; lane c sees column c of B
	always_comb begin
		for (int k = 0; k < DIM; k++) begin
			a_sel[k] = a_rows_q[issue_row_q][k];
			for (int c = 0; c < DIM; c++) begin
				b_col[c][k] = b_rows_q[k][c];
			end
		end
	end

	for (genvar c = 0; c < DIM; c++) begin : g_lane
		mtx4_lane #(
			.WORD_BITS(WORD_BITS)
		) u_lane (
			.clk    (clk),
			.en     (adv),
			.a_row  (a_sel),
			.b_col  (b_col[c]),
			.sum_s2 (lane_sum[c])
		);
	end

	mtx4_merge #(
		.WORD_BITS(WORD_BITS)
	) u_merge (
		.clk   (clk),
		.en    (adv),
		.sum   (lane_sum),
		.ctl   (ctl_s2),
		.c_q   (c_q),
		.ctl_q (ctl_out)
	);

	assign out_valid = out_valid_q;
	assign c_e0      = c_q[0];
	assign c_e1      = c_q[1];
	assign c_e2      = c_q[2];
	assign c_e3      = c_q[3];
	assign out_row   = ctl_out.row;
	assign last_row  = ctl_out.last;

	// Accepting the fourth row must start issuing in the next cycle
	a_run_after_row3: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && load_row_q == ROW_BITS'(DIM - 1)) |=> (state_q == ST_RUN))
		else $error("fourth row accepted without starting the product");

	// While issuing, loading always restarts from row 0
	a_run_load_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (load_row_q == '0))
		else $error("load slot not at row 0 while issuing");

	// The last flag marks exactly the final row of the product
	a_last_matches_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_row == (out_row == ROW_BITS'(DIM - 1))))
		else $error("last_row does not match out_row");

	// When a product starts issuing, the valid bits hold at most three rows
	a_inflight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && issue_row_q == '0) |-> ($countones({v_s1, v_s2, out_valid_q}) <= 3))
		else $error("pipeline holds more rows than one product");

endmodule

### dv/tb_matrix4x4_multiply.sv
`timescale 1ns / 100ps
// Self-checking testbench for matrix4x4_multiply: Q16.16 4x4 products checked row by row.
// Depends on mtx4_pkg and the matrix4x4_multiply RTL, including mtx4_lane and mtx4_merge.
module tb_matrix4x4_multiply;
	import mtx4_pkg::*;

	localparam int WORD_BITS = 32;
	localparam int MIX_BITS  = 68;   // four 64-bit products plus headroom, never wraps

	typedef logic [WORD_BITS-1:0]          word_t;
	typedef logic [DIM-1:0][WORD_BITS-1:0] row4_t;
	typedef logic [DIM-1:0][DIM-1:0][WORD_BITS-1:0] mat_t;

	typedef struct packed {
		row4_t    c;
		row_ctl_t ctl;
	} c_row_t;

	localparam word_t WORD_MAX = 32'h7FFF_FFFF;
	localparam word_t WORD_MIN = 32'h8000_0000;
	localparam word_t Q_ONE    = 32'h0001_0000;
	localparam logic signed [MIX_BITS-1:0] SAT_HI = 68'sh7FFF_FFFF;
	localparam logic signed [MIX_BITS-1:0] SAT_LO = -68'sh8000_0000;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	word_t a_e0, a_e1, a_e2, a_e3;
	word_t b_e0, b_e1, b_e2, b_e3;
	logic out_valid;
	logic out_ready;
	logic signed [WORD_BITS-1:0] c_e0, c_e1, c_e2, c_e3;
	logic [ROW_BITS-1:0] out_row;
	logic last_row;

	// Mirror of the block's operand stores and its row pointer
	row4_t               left_rows [DIM];
	row4_t               right_rows[DIM];
	logic [ROW_BITS-1:0] next_load_row;

	c_row_t pending_c_rows[$];
	int     mismatch_count;
	int     send_idle_pct;
	int     recv_stall_pct;
	int     ready_hold_cycles;

	matrix4x4_multiply #(
		.WORD_BITS(WORD_BITS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.a_e0     (a_e0),
		.a_e1     (a_e1),
		.a_e2     (a_e2),
		.a_e3     (a_e3),
		.b_e0     (b_e0),
		.b_e1     (b_e1),
		.b_e2     (b_e2),
		.b_e3     (b_e3),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.c_e0     (c_e0),
		.c_e1     (c_e1),
		.c_e2     (c_e2),
		.c_e3     (c_e3),
		.out_row  (out_row),
		.last_row (last_row)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shift the exact dot product down by the fraction bits (floor) and clamp to one word.
	function automatic word_t shift_and_clamp(input logic signed [MIX_BITS-1:0] dot);
		logic signed [MIX_BITS-1:0] shifted;
		shifted = dot >>> FRAC_BITS;
		if (shifted > SAT_HI)
			return WORD_MAX;
		if (shifted < SAT_LO)
			return WORD_MIN;
		return shifted[WORD_BITS-1:0];
	endfunction

	// Store one accepted row pair; on the fourth row queue all four product rows.
	task automatic absorb_row_pair(input row4_t a_row, input row4_t b_row);
		c_row_t                     prod;
		logic signed [MIX_BITS-1:0] dot;
		logic signed [MIX_BITS-1:0] lhs;
		logic signed [MIX_BITS-1:0] rhs;
		left_rows[next_load_row]  = a_row;
		right_rows[next_load_row] = b_row;
		if (next_load_row == ROW_BITS'(DIM - 1)) begin
			for (int r = 0; r < DIM; r++) begin
				for (int c = 0; c < DIM; c++) begin
					dot = '0;
					for (int k = 0; k < DIM; k++) begin
						lhs = $signed(left_rows[r][k]);
						rhs = $signed(right_rows[k][c]);
						dot = dot + lhs * rhs;
					end
					prod.c[c] = shift_and_clamp(dot);
				end
				prod.ctl.row  = ROW_BITS'(r);
				prod.ctl.last = (r == DIM - 1);
				pending_c_rows.push_back(prod);
			end
		end
		next_load_row = next_load_row + 1'b1;
	endtask

	function automatic int draw_gap(input int pct);
		int n;
		n = 0;
		while ($urandom_range(99) < pct)
			n++;
		return n;
	endfunction

	// Mix full-range words, values near Q16.16 unity, medium values and corner codes.
	function automatic word_t rand_word();
		int v;
		case ($urandom_range(3))
			0: return $urandom;
			1: begin
				v = $urandom_range(524288);
				return word_t'(v - 262144);
			end
			2: begin
				v = $urandom_range(16777216);
				return word_t'(v - 8388608);
			end
			default: begin
				case ($urandom_range(5))
					0: return WORD_MAX;
					1: return WORD_MIN;
					2: return '0;
					3: return '1;
					4: return word_t'(1);
					default: return Q_ONE;
				endcase
			end
		endcase
	endfunction

	// Offer one row pair, hold it until the transaction completes, then predict.
	task automatic send_row_pair(input row4_t a_row, input row4_t b_row);
		int gap;
		gap = draw_gap(send_idle_pct);
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid = 1'b1;
		{a_e3, a_e2, a_e1, a_e0} = a_row;
		{b_e3, b_e2, b_e1, b_e0} = b_row;
		do @(posedge clk); while (!in_ready);
		absorb_row_pair(a_row, b_row);
	endtask

	task automatic send_matrices(input mat_t a_mat, input mat_t b_mat);
		for (int r = 0; r < DIM; r++)
			send_row_pair(a_mat[r], b_mat[r]);
	endtask

	function automatic mat_t fill_matrix(input word_t value);
		mat_t m;
		for (int r = 0; r < DIM; r++)
			for (int c = 0; c < DIM; c++)
				m[r][c] = value;
		return m;
	endfunction

	function automatic mat_t rand_matrix();
		mat_t m;
		for (int r = 0; r < DIM; r++)
			for (int c = 0; c < DIM; c++)
				m[r][c] = rand_word();
		return m;
	endfunction

	// Drop valid, then wait for every queued product row to come out.
	task automatic drain_products();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_c_rows.size() != 0)
			@(posedge clk);
	endtask

	// Identity times a random matrix, and floor rounding of tiny negative products.
	task automatic test_identity_and_rounding();
		mat_t ident;
		mat_t tiny;
		ident = fill_matrix('0);
		for (int i = 0; i < DIM; i++)
			ident[i][i] = Q_ONE;
		send_matrices(ident, rand_matrix());
		tiny = fill_matrix(word_t'(1));
		send_matrices(fill_matrix('1), tiny);
		drain_products();
	endtask

	// Drive every element to the extremes so each element clamps both ways.
	task automatic test_saturation();
		send_matrices(fill_matrix(WORD_MAX), fill_matrix(WORD_MAX));
		send_matrices(fill_matrix(WORD_MIN), fill_matrix(WORD_MIN));
		send_matrices(fill_matrix(WORD_MAX), fill_matrix(WORD_MIN));
		drain_products();
	endtask

	task automatic test_random_products(input int idle_pct, input int stall_pct, input int n);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < n; i++)
			send_matrices(rand_matrix(), rand_matrix());
		drain_products();
	endtask

	// Block the output long enough that the block fills and pushes back on the input.
	task automatic test_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		@(posedge clk);
		ready_hold_cycles = 80;
		for (int i = 0; i < 3; i++)
			send_matrices(rand_matrix(), rand_matrix());
		drain_products();
	endtask

	// Receiver: hold ready low during a forced hold-off, otherwise stall at random.
	always @(negedge clk) begin
		if (ready_hold_cycles > 0) begin
			out_ready = 1'b0;
			ready_hold_cycles = ready_hold_cycles - 1;
		end else begin
			out_ready = ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Checker: compare each output transaction with the oldest predicted row.
	always @(posedge clk) begin
		c_row_t want;
		row4_t  got;
		if (arst_n && out_valid && out_ready) begin
			got = {c_e3, c_e2, c_e1, c_e0};
			if (pending_c_rows.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("ERROR: unexpected row %0d c=%h %h %h %h last=%b",
						out_row, c_e0, c_e1, c_e2, c_e3, last_row);
			end else begin
				want = pending_c_rows.pop_front();
				if (got[0] !== want.c[0] || got[1] !== want.c[1] ||
				    got[2] !== want.c[2] || got[3] !== want.c[3] ||
				    out_row !== want.ctl.row || last_row !== want.ctl.last) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("ERROR: expected row %0d c=%h %h %h %h last=%b",
							want.ctl.row, want.c[0], want.c[1], want.c[2], want.c[3],
							want.ctl.last);
						$display("       actual   row %0d c=%h %h %h %h last=%b",
							out_row, c_e0, c_e1, c_e2, c_e3, last_row);
					end
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		arst_n            = 1'b0;
		in_valid          = 1'b0;
		out_ready         = 1'b0;
		{a_e3, a_e2, a_e1, a_e0} = '0;
		{b_e3, b_e2, b_e1, b_e0} = '0;
		next_load_row     = '0;
		mismatch_count    = 0;
		send_idle_pct     = 0;
		recv_stall_pct    = 0;
		ready_hold_cycles = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_identity_and_rounding();
		test_saturation();
		test_random_products(0, 0, 25);
		test_random_products(61, 0, 25);
		test_random_products(0, 61, 25);
		test_random_products(20, 20, 25);
		test_backpressure();

		// Let any stray row surface before the verdict.
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
